[rtl/char_lcd_command_sequencer_assert.svh]
// assertion macros for the character lcd command sequencer
// the bodies sample on clk and are disabled while rst is high
`ifndef CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LCDSEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LCDSEQ_ASSERT_NOW(label, ante, cons, msg)
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/lcdseq_pkg.sv]
// shared types and constants for the character lcd command sequencer
// no dependencies
package lcdseq_pkg;

  // request codes
  localparam logic [2:0] OP_POLL      = 3'd0;
  localparam logic [2:0] OP_SET_CUR   = 3'd1;
  localparam logic [2:0] OP_STR_START = 3'd2;
  localparam logic [2:0] OP_STR_CHAR  = 3'd3;
  localparam logic [2:0] OP_SHIFT_R   = 3'd4;
  localparam logic [2:0] OP_SHIFT_L   = 3'd5;

  // sequencer phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_WAIT_BUSY  = 3'd1;
  localparam logic [2:0] PH_WAIT_ADDR  = 3'd2;
  localparam logic [2:0] PH_PUT        = 3'd3;
  localparam logic [2:0] PH_FINISH     = 3'd4;
  localparam logic [2:0] PH_STOP_SHIFT = 3'd5;

  // lcd command bytes
  localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
  localparam logic [7:0] CMD_SHIFT        = 8'h10;
  localparam logic [7:0] SHIFT_RIGHT_BIT  = 8'h04;
  localparam logic [7:0] SHIFT_SCREEN_BIT = 8'h08;
  localparam logic [7:0] SPACE_CODE       = 8'h20;

  localparam int IN_BITS  = 48;
  localparam int OUT_BITS = 16;

  // last field in the lowest bits
  typedef struct packed {
    logic [7:0] pad_length;
    logic [7:0] char_code;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] status_byte;
    logic [2:0] op;
  } in_item_t;

  typedef struct packed {
    logic       busy_res;
    logic       need_char;
    logic       done_res;
    logic [7:0] write_byte;
    logic       write_is_data;
    logic       write_valid;
    logic       accepted;
  } out_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] phase_after_wait;
    logic [6:0] expected_address;
    logic [7:0] pad_remaining;
    logic       string_ended;
  } seq_state_t;

endpackage

[rtl/lcdseq_core.sv]
// sequencer state and the per-item step logic
// depends on lcdseq_pkg and char_lcd_command_sequencer_assert.svh
`include "char_lcd_command_sequencer_assert.svh"

module lcdseq_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  lcdseq_pkg::in_item_t  item,
  output lcdseq_pkg::out_item_t res
);

  lcdseq_pkg::seq_state_t state;
  lcdseq_pkg::seq_state_t state_next;

  logic       do_put;
  logic [7:0] put_c;
  logic       idle;

  always_comb begin
    state_next = state;
    res        = '0;
    do_put     = 1'b0;
    put_c      = 8'h00;
    idle       = (state.phase == lcdseq_pkg::PH_IDLE);

    unique case (item.op)
      lcdseq_pkg::OP_POLL: begin
        unique case (state.phase)
          lcdseq_pkg::PH_WAIT_BUSY: begin
            if (!item.status_byte[7]) state_next.phase = state.phase_after_wait;
          end
          lcdseq_pkg::PH_WAIT_ADDR: begin
            if (item.status_byte == {1'b0, state.expected_address})
              state_next.phase = state.phase_after_wait;
          end
          lcdseq_pkg::PH_PUT: begin
            // padding runs on poll ticks once the string has ended
            if (state.string_ended) do_put = 1'b1;
          end
          lcdseq_pkg::PH_FINISH: begin
            state_next.phase = lcdseq_pkg::PH_IDLE;
            res.done_res     = 1'b1;
          end
          lcdseq_pkg::PH_STOP_SHIFT: begin
            res.write_valid            = 1'b1;
            res.write_byte             = lcdseq_pkg::CMD_SHIFT;
            state_next.phase_after_wait = lcdseq_pkg::PH_FINISH;
            state_next.phase           = lcdseq_pkg::PH_WAIT_BUSY;
          end
          default: begin
          end
        endcase
      end
      lcdseq_pkg::OP_SET_CUR: begin
        if (idle) begin
          res.accepted                = 1'b1;
          state_next.expected_address = {item.row[0], item.column[5:0]};
          res.write_valid             = 1'b1;
          res.write_byte              = lcdseq_pkg::CMD_SET_ADDR |
                                        {1'b0, item.row[0], item.column[5:0]};
          state_next.phase_after_wait = lcdseq_pkg::PH_FINISH;
          state_next.phase            = lcdseq_pkg::PH_WAIT_ADDR;
        end
      end
      lcdseq_pkg::OP_STR_START: begin
        if (idle) begin
          res.accepted             = 1'b1;
          state_next.pad_remaining = item.pad_length;
          state_next.string_ended  = 1'b0;
          do_put                   = 1'b1;
          put_c                    = item.char_code;
        end
      end
      lcdseq_pkg::OP_STR_CHAR: begin
        if (state.phase == lcdseq_pkg::PH_PUT && !state.string_ended) begin
          res.accepted = 1'b1;
          do_put       = 1'b1;
          put_c        = item.char_code;
        end
      end
      lcdseq_pkg::OP_SHIFT_R, lcdseq_pkg::OP_SHIFT_L: begin
        if (idle) begin
          res.accepted                = 1'b1;
          res.write_valid             = 1'b1;
          res.write_byte              = lcdseq_pkg::CMD_SHIFT | lcdseq_pkg::SHIFT_SCREEN_BIT |
                                        ((item.op == lcdseq_pkg::OP_SHIFT_R) ?
                                         lcdseq_pkg::SHIFT_RIGHT_BIT : 8'h00);
          state_next.phase_after_wait = lcdseq_pkg::PH_STOP_SHIFT;
          state_next.phase            = lcdseq_pkg::PH_WAIT_BUSY;
        end
      end
      default: begin
      end
    endcase

    // one character: data write, or end of string with optional pad space
    if (do_put) begin
      if (put_c != 8'h00) begin
        res.write_valid             = 1'b1;
        res.write_is_data           = 1'b1;
        res.write_byte              = put_c;
        state_next.phase_after_wait = lcdseq_pkg::PH_PUT;
      end else begin
        state_next.string_ended = 1'b1;
        if (state_next.pad_remaining != 8'h00) begin
          res.write_valid   = 1'b1;
          res.write_is_data = 1'b1;
          res.write_byte    = lcdseq_pkg::SPACE_CODE;
        end
        state_next.phase_after_wait = (state_next.pad_remaining > 8'd1) ?
                                      lcdseq_pkg::PH_PUT : lcdseq_pkg::PH_FINISH;
      end
      // counts down and sticks at zero, so long strings still go out in full
      if (state_next.pad_remaining != 8'h00)
        state_next.pad_remaining = state_next.pad_remaining - 8'd1;
      state_next.phase = lcdseq_pkg::PH_WAIT_BUSY;
    end

    res.need_char = (state_next.phase == lcdseq_pkg::PH_PUT) && !state_next.string_ended;
    res.busy_res  = (state_next.phase != lcdseq_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  `LCDSEQ_ASSERT_NEXT(a_done_goes_idle, step && res.done_res,
                      state.phase == lcdseq_pkg::PH_IDLE, "done without return to idle")
  `LCDSEQ_ASSERT_NEXT(a_data_waits_busy, step && res.write_valid && res.write_is_data,
                      state.phase == lcdseq_pkg::PH_WAIT_BUSY, "data write not followed by busy wait")
  `LCDSEQ_ASSERT_NEXT(a_cursor_waits_addr,
                      step && res.accepted && item.op == lcdseq_pkg::OP_SET_CUR,
                      state.phase == lcdseq_pkg::PH_WAIT_ADDR, "cursor set without address wait")
  `LCDSEQ_ASSERT_NOW(a_addr_then_finish, state.phase == lcdseq_pkg::PH_WAIT_ADDR,
                     state.phase_after_wait == lcdseq_pkg::PH_FINISH, "address wait not ending op")

endmodule

[rtl/char_lcd_command_sequencer.sv]
// character lcd command sequencer: input register, step core, result register
// depends on lcdseq_pkg and lcdseq_core
//
// usage: every item on the slave stream is either a poll tick carrying the lcd
// status byte or a request (set cursor, start string, string character, shift
// right, shift left). each accepted item yields exactly one result item on the
// master stream: whether the request was taken, an optional lcd write (command
// or data byte), a done pulse at the end of an operation, and need_char and
// busy flags as they stand after the item.
// path: an accepted item waits in the input register, and its result is held in
// the result register.
// throughput: one item per cycle while m_tready is high; the step core updates its
// phase register once per item, so the core does not limit the rate below that.
// reset: the sequencer returns to idle and both registers empty.
// stall: while m_tready is low the result is held; one more item may enter the
// input register, after which s_tready drops until the result is taken.
module char_lcd_command_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // op, status_byte, column, row, char_code, pad_length, zero fill
  input  logic [lcdseq_pkg::IN_BITS-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // accepted, write_valid, write_is_data, write_byte, done_res, need_char,
  // busy_res, zero fill
  output logic [lcdseq_pkg::OUT_BITS-1:0] m_tdata
);

  localparam int InFieldBits  = $bits(lcdseq_pkg::in_item_t);
  localparam int OutFieldBits = $bits(lcdseq_pkg::out_item_t);

  lcdseq_pkg::in_item_t  in_item;
  logic                  in_valid;
  lcdseq_pkg::out_item_t out_item;
  logic                  out_valid;
  lcdseq_pkg::out_item_t step_res;
  logic                  advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= lcdseq_pkg::in_item_t'(s_tdata[InFieldBits-1:0]);
    end
  end

  lcdseq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(lcdseq_pkg::OUT_BITS - OutFieldBits){1'b0}}, out_item};

endmodule
